@@ rtl/core/bsmmg_pkg.sv @@
// Shared constants, types and span arithmetic for the bounded set block.
// No dependencies; bsmmg_if and bounded_set_min_max_gap use this package.
package bsmmg_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 7;
  localparam int CNT_OUT_W   = 7;
  localparam int CMP_W       = CNT_W + CAP_W;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [AW-1:0]     addr_t;

  // Flip the sign bit so unsigned order matches signed order.
  function automatic word_t order_key(input word_t v);
    return v ^ {1'b1, {(DATA_W-1){1'b0}}};
  endfunction

  function automatic word_t distance(input word_t a, input word_t b);
    word_t ka;
    word_t kb;
    ka = order_key(a);
    kb = order_key(b);
    return (ka >= kb) ? (ka - kb) : (kb - ka);
  endfunction

endpackage

@@ rtl/core/bsmmg_if.sv @@
// Valid/ready channels for the bounded set block: input items and result items.
// Depends on bsmmg_pkg for field widths.
interface bsmmg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsmmg_pkg::DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bsmmg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 status;
  logic [bsmmg_pkg::CNT_OUT_W-1:0]      count;
  logic                                 spans_valid;
  logic [bsmmg_pkg::DATA_W-1:0]         shortest_span;
  logic [bsmmg_pkg::DATA_W-1:0]         longest_span;

  modport source (output valid, output status, output count, output spans_valid,
                  output shortest_span, output longest_span, input ready);
  modport sink   (input valid, input status, input count, input spans_valid,
                  input shortest_span, input longest_span, output ready);
endinterface

@@ rtl/core/bounded_set_min_max_gap.sv @@
// Bounded set with shortest and longest span. An accepted item that is added to
// a set holding N numbers is compared with each of them, the
// scan reading one held number per cycle from the RAM; a rejected item or an
// empty set does not read the RAM. One item is in flight at a time; the next is taken
// as soon as the result register is loaded. Reset clears count, extremes and
// capacity and sets the gap to all ones; the number RAM is not cleared and needs no pass.
module bounded_set_min_max_gap (
  input  logic                          clk,
  input  logic                          rst,
  bsmmg_in_if.sink                      din,
  bsmmg_out_if.source                   dout,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsmmg_pkg::PADDR_W-1:0] paddr,
  input  logic [bsmmg_pkg::PDATA_W-1:0] pwdata,
  output logic [bsmmg_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import bsmmg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_SPAN = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state;
  logic [CAP_W-1:0] capacity;

  cnt_t  held_count;
  word_t smallest_held;
  word_t largest_held;
  word_t min_gap;

  word_t v;
  logic  reject;
  cnt_t  count_new;
  word_t sm_new;
  word_t lg_new;
  word_t gap_acc;
  word_t span;
  cnt_t  scan_len;
  cnt_t  issue_idx;
  logic  rd_v;
  word_t pair_gap;
  logic  dist_v;

  logic             out_valid;
  logic             out_status;
  logic [CNT_OUT_W-1:0] out_count;
  logic             out_spans_valid;
  word_t            out_shortest;
  word_t            out_longest;

  word_t rdata;
  logic  issue;
  logic  out_free;
  logic  commit;
  logic  spans_ok;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] limit;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign cap_ext = CMP_W'(capacity);
  assign limit   = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;

  assign din.ready = (state == ST_IDLE);
  assign issue     = (state == ST_SCAN) && (issue_idx < scan_len);
  assign out_free  = !out_valid || dout.ready;
  assign commit    = (state == ST_FIN) && out_free;
  assign spans_ok  = (count_new >= CNT_W'(2));

  bsmmg_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (commit && !reject),
    .waddr (held_count[AW-1:0]),
    .wdata (v),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held_count    <= '0;
      smallest_held <= '0;
      largest_held  <= '0;
      min_gap       <= '1;
      rd_v          <= 1'b0;
      dist_v        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_v   <= issue;
      dist_v <= rd_v;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (din.valid) begin
            v     <= word_t'(din.value);
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          reject    <= (CMP_W'(held_count) >= limit);
          issue_idx <= '0;
          gap_acc   <= min_gap;
          if (CMP_W'(held_count) >= limit) begin
            count_new <= held_count;
            scan_len  <= '0;
            sm_new    <= smallest_held;
            lg_new    <= largest_held;
          end else begin
            count_new <= held_count + CNT_W'(1);
            scan_len  <= held_count;
            if (held_count == '0) begin
              sm_new <= v;
              lg_new <= v;
            end else begin
              sm_new <= (order_key(v) < order_key(smallest_held)) ? v : smallest_held;
              lg_new <= (order_key(v) > order_key(largest_held)) ? v : largest_held;
            end
          end
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (rd_v) begin
            pair_gap <= distance(v, rdata);
          end
          if (dist_v && pair_gap < gap_acc) begin
            gap_acc <= pair_gap;
          end
          // Drain the read and distance stages before leaving.
          if (!issue && !rd_v && !dist_v) begin
            state <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          span  <= distance(lg_new, sm_new);
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_status      <= reject;
            out_count       <= CNT_OUT_W'(count_new);
            out_spans_valid <= spans_ok;
            out_shortest    <= spans_ok ? gap_acc : '0;
            out_longest     <= spans_ok ? span : '0;
            if (!reject) begin
              held_count    <= count_new;
              smallest_held <= sm_new;
              largest_held  <= lg_new;
              min_gap       <= gap_acc;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign dout.valid         = out_valid;
  assign dout.status        = out_status;
  assign dout.count         = out_count;
  assign dout.spans_valid   = out_spans_valid;
  assign dout.shortest_span = out_shortest;
  assign dout.longest_span  = out_longest;

endmodule

@@ rtl/core/bsmmg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bsmmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
